// ===== hdl/ohm_pkg.sv =====
// Shared types, constants and the hex digit decoder for the OBD response matcher.
// Used by ohm_token, ohm_match and obd_response_hex_matcher_core.
package ohm_pkg;

    localparam int unsigned DATA_FIELDS     = 8;
    localparam int unsigned MAX_DATA_DEF    = 8;
    localparam int unsigned CFG_IDX_W       = 1;
    localparam int unsigned CFG_DATA_W      = 8;
    localparam int unsigned COUNT_W         = 4;
    localparam int unsigned OUT_TDATA_W     = 72;
    localparam logic [7:0]  RESPONSE_OFFSET = 8'h40;
    localparam logic [7:0]  MODE_RESET      = 8'h01;
    localparam logic [7:0]  PID_RESET       = 8'h0C;

    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_PID  = 1'b1;

    typedef struct packed {
        logic       step;
        logic       last;
        logic [7:0] text_char;
    } t_char_in;

    typedef struct packed {
        logic       step;
        logic       last;
        logic       has_byte;
        logic [7:0] value;
    } t_byte_evt;

    typedef struct packed {
        logic                             found;
        logic [COUNT_W-1:0]               byte_count;
        logic [DATA_FIELDS-1:0][7:0]      data;
    } t_result;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } t_digit;

    function automatic t_digit digit_of(input logic [7:0] c);
        t_digit d;
        d.is_hex = 1'b1;
        d.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.value = c[3:0];
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            d.value = c[3:0] + 4'd9;
        end else begin
            d.is_hex = 1'b0;
        end
        return d;
    endfunction

endpackage

// ===== hdl/ohm_token.sv =====
// Hex tokenizer: gathers runs of hex digits and emits a byte for each
// two-digit token. Depends on ohm_pkg.
module ohm_token
    import ohm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_char_in  i_char,
    output t_byte_evt o_evt
);

    logic [1:0] r_len, n_len;
    logic [7:0] r_val, n_val;
    t_digit     w_dig;
    logic [1:0] w_len_inc;
    logic [7:0] w_val_sh;

    always_comb begin
        w_dig     = digit_of(i_char.text_char);
        w_len_inc = (r_len == 2'd3) ? 2'd3 : r_len + 2'd1;
        w_val_sh  = {r_val[3:0], w_dig.value};
        n_len     = r_len;
        n_val     = r_val;
        o_evt.step     = i_char.step;
        o_evt.last     = i_char.last;
        o_evt.has_byte = 1'b0;
        o_evt.value    = r_val;
        if (i_char.step) begin
            if (w_dig.is_hex) begin
                n_len = w_len_inc;
                n_val = w_val_sh;
                if (i_char.last) begin
                    o_evt.has_byte = (w_len_inc == 2'd2);
                    o_evt.value    = w_val_sh;
                    n_len          = 2'd0;
                    n_val          = 8'd0;
                end
            end else begin
                // separator flushes; a second flush on the last item is empty
                o_evt.has_byte = (r_len == 2'd2);
                o_evt.value    = r_val;
                n_len          = 2'd0;
                n_val          = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= 2'd0;
            r_val <= 8'd0;
        end else begin
            r_len <= n_len;
            r_val <= n_val;
        end
    end

endmodule

// ===== hdl/ohm_match.sv =====
// Mode/PID pair search and data byte capture; builds the result on the last item.
// Depends on ohm_pkg.
module ohm_match
    import ohm_pkg::*;
#(
    parameter int unsigned MAX_DATA_BYTES = MAX_DATA_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [7:0] i_request_mode,
    input  logic [7:0] i_request_pid,
    input  t_byte_evt i_evt,
    output t_result   o_result
);

    localparam int unsigned CAP = (MAX_DATA_BYTES < DATA_FIELDS) ? MAX_DATA_BYTES : DATA_FIELDS;
    localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAP);

    logic [7:0]         r_prev, n_prev;
    logic               r_prev_vld, n_prev_vld;
    logic               r_matched, n_matched;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [7:0]         r_bytes [CAP];
    logic [7:0]         n_bytes [CAP];
    logic [7:0]         w_resp;

    always_comb begin
        w_resp     = i_request_mode + RESPONSE_OFFSET;
        n_prev     = r_prev;
        n_prev_vld = r_prev_vld;
        n_matched  = r_matched;
        n_count    = r_count;
        for (int k = 0; k < CAP; k++) begin
            n_bytes[k] = r_bytes[k];
        end
        if (i_evt.step && i_evt.has_byte) begin
            if (r_matched) begin
                if (r_count < CAP_CNT) begin
                    for (int k = 0; k < CAP; k++) begin
                        if (r_count == COUNT_W'(k)) begin
                            n_bytes[k] = i_evt.value;
                        end
                    end
                    n_count = r_count + COUNT_W'(1);
                end
            end else if (r_prev_vld && r_prev == w_resp && i_evt.value == i_request_pid) begin
                n_matched = 1'b1;
                n_count   = '0;
            end else begin
                n_prev     = i_evt.value;
                n_prev_vld = 1'b1;
            end
        end

        o_result.found      = n_matched;
        o_result.byte_count = n_matched ? n_count : '0;
        for (int k = 0; k < DATA_FIELDS; k++) begin
            o_result.data[k] = 8'd0;
        end
        for (int k = 0; k < CAP; k++) begin
            if (n_matched && COUNT_W'(k) < n_count) begin
                o_result.data[k] = n_bytes[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_vld <= 1'b0;
            r_matched  <= 1'b0;
            r_count    <= '0;
        end else if (i_evt.step && i_evt.last) begin
            r_prev_vld <= 1'b0;
            r_matched  <= 1'b0;
            r_count    <= '0;
        end else begin
            r_prev_vld <= n_prev_vld;
            r_matched  <= n_matched;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        for (int k = 0; k < CAP; k++) begin
            r_bytes[k] <= n_bytes[k];
        end
    end

endmodule

// ===== hdl/obd_response_hex_matcher_core.sv =====
// OBD mode/PID response matcher, top level: input register, tokenizer,
// matcher and result register. Depends on ohm_pkg, ohm_token, ohm_match.
//
// Usage: reply text enters one character per item on the s_axis channel,
// tlast marking the final character. One result item leaves on m_axis for
// each reply, carrying found, byte count and eight data bytes.
// Configuration (request mode, request PID) is written through i_cfg_*; the user must
// write it only while no reply is in flight, as the block does not enforce this. Writes take effect at once.
// Throughput: one character per cycle, except that a final character holds while a
// result is still pending on a stalled m_axis. The final character passes through
// the input register, then the result register is loaded from the combinational token/match logic.
// When m_axis stalls, characters keep flowing until a second final character
// reaches the input register; it then holds and s_axis tready drops until
// the pending result is taken.
// Reset clears token, match state and both valid flags, and restores the
// request mode to 0x01 and the request PID to 0x0C.
module obd_response_hex_matcher_core
    import ohm_pkg::*;
#(
    parameter int unsigned MAX_DATA_BYTES = MAX_DATA_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [7:0]             i_s_axis_tdata,  // text_char
    input  logic                   i_s_axis_tlast,  // end_of_text
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // found, byte_count[3:0], data_0 .. data_7, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic       r_in_vld;
    logic       r_in_last;
    logic [7:0] r_in_char;
    logic       w_adv;
    logic       r_out_vld;
    t_result    r_out;
    logic [7:0] r_request_mode;
    logic [7:0] r_request_pid;
    t_char_in   w_char;
    t_byte_evt  w_evt;
    t_result    w_result;

    assign w_adv           = r_in_vld && (!r_in_last || !r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_request_mode <= MODE_RESET;
            r_request_pid  <= PID_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REQUEST_MODE: r_request_mode <= i_cfg_data;
                CFG_REQUEST_PID:  r_request_pid  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_char <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    assign w_char.step      = w_adv;
    assign w_char.last      = r_in_last;
    assign w_char.text_char = r_in_char;

    ohm_token u_token (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (w_char),
        .o_evt   (w_evt)
    );

    ohm_match #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_match (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_request_mode (r_request_mode),
        .i_request_pid  (r_request_pid),
        .i_evt          (w_evt),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {3'b000, r_out.data, r_out.byte_count, r_out.found};

    a_no_data_without_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.found) |-> (r_out.byte_count == '0 && r_out.data == '0))
        else $error("data or count set without found");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.byte_count <= COUNT_W'(DATA_FIELDS)))
        else $error("byte count above data fields");

    a_hold_last_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_in_last && r_out_vld && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("final item advanced over a pending result");

    a_result_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> r_out_vld)
        else $error("final item produced no result");

endmodule

// ===== tb/sv/obd_response_hex_matcher_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for obd_response_hex_matcher_core: streams reply text items, predicts
// each reply result with a behavioral matcher and checks every m_axis item.
// Depends on ohm_pkg and the core RTL.
module obd_response_hex_matcher_core_tb;
    import ohm_pkg::*;

    localparam int CAPTURE_LIMIT = (MAX_DATA_DEF < DATA_FIELDS) ? MAX_DATA_DEF : DATA_FIELDS;
    localparam int RANDOM_ITEMS  = 1900;

    typedef struct packed {
        logic                        found;
        logic [COUNT_W-1:0]          count;
        logic [DATA_FIELDS-1:0][7:0] data;
    } t_reply_result;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic [7:0]             i_s_axis_tdata  = 8'h00;
    logic                   i_s_axis_tlast  = 1'b0;
    logic                   i_m_axis_tready = 1'b0;
    logic                   i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index     = CFG_REQUEST_MODE;
    logic [CFG_DATA_W-1:0]  i_cfg_data      = '0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    obd_response_hex_matcher_core #(
        .MAX_DATA_BYTES(MAX_DATA_DEF)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tlast (i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // matcher model state
    logic [7:0]                  cfg_mode = MODE_RESET;
    logic [7:0]                  cfg_pid  = PID_RESET;
    logic [1:0]                  tok_len;
    logic [7:0]                  tok_val;
    logic [7:0]                  last_byte;
    logic                        last_byte_ok;
    logic                        pair_seen;
    logic [COUNT_W-1:0]          capture_cnt;
    logic [DATA_FIELDS-1:0][7:0] capture_data;

    t_reply_result expected_results[$];
    logic [7:0]    reply_text[$];
    t_reply_result head;
    int            field_idx;
    int            errors      = 0;
    int            items_sent  = 0;
    bit            quiet_phase = 1'b0;

    function automatic void add_char(input logic [7:0] c);
        reply_text.insert(reply_text.size(), c);
    endfunction

    function automatic void clear_matcher();
        tok_len      = 2'd0;
        tok_val      = 8'h00;
        last_byte    = 8'h00;
        last_byte_ok = 1'b0;
        pair_seen    = 1'b0;
        capture_cnt  = '0;
        capture_data = '0;
    endfunction

    // bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] decode_hex(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
        if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
        if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
        return 5'd0;
    endfunction

    function automatic void take_stream_byte(input logic [7:0] b);
        logic [7:0] resp;
        resp = cfg_mode + RESPONSE_OFFSET;
        if (pair_seen) begin
            if (capture_cnt < CAPTURE_LIMIT) begin
                capture_data[capture_cnt] = b;
                capture_cnt++;
            end
        end else if (last_byte_ok && last_byte == resp && b == cfg_pid) begin
            pair_seen   = 1'b1;
            capture_cnt = '0;
        end else begin
            last_byte    = b;
            last_byte_ok = 1'b1;
        end
    endfunction

    function automatic void flush_token();
        if (tok_len == 2'd2) take_stream_byte(tok_val);
        tok_len = 2'd0;
        tok_val = 8'h00;
    endfunction

    function automatic void predict_char(input logic [7:0] c, input logic is_last);
        logic [4:0]    d;
        t_reply_result r;
        int            k;
        d = decode_hex(c);
        if (d[4]) begin
            tok_val = {tok_val[3:0], d[3:0]};
            if (tok_len != 2'd3) tok_len++;
        end else begin
            flush_token();
        end
        if (is_last) begin
            flush_token();
            r.found = pair_seen;
            r.count = pair_seen ? capture_cnt : '0;
            for (k = 0; k < DATA_FIELDS; k++)
                r.data[k] = (pair_seen && k < capture_cnt) ? capture_data[k] : 8'h00;
            expected_results.insert(expected_results.size(), r);
            clear_matcher();
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h",
                         $time, o_m_axis_tdata);
                errors++;
            end else begin
                head = expected_results.pop_front();
                check_field("found", head.found, o_m_axis_tdata[0]);
                check_field("byte_count", head.count, o_m_axis_tdata[4:1]);
                for (field_idx = 0; field_idx < DATA_FIELDS; field_idx++)
                    check_field($sformatf("data_%0d", field_idx), head.data[field_idx],
                                o_m_axis_tdata[5 + 8 * field_idx +: 8]);
            end
        end
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= quiet_phase || ($urandom_range(0, 99) >= 32);
    end

    task automatic send_item(input logic [7:0] c, input logic is_last);
        while (!quiet_phase && $urandom_range(0, 99) < 32) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        i_s_axis_tlast  <= is_last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_char(c, is_last);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_reply();
        int i;
        for (i = 0; i < reply_text.size(); i++)
            send_item(reply_text[i], i == reply_text.size() - 1);
        reply_text.delete();
    endtask

    // stop sending and let every pending result leave the block
    task automatic wait_drain();
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        if (idx == CFG_REQUEST_MODE) cfg_mode = value;
        else cfg_pid = value;
    endtask

    task automatic set_request(input logic [7:0] mode, input logic [7:0] pid);
        wait_drain();
        write_register(CFG_REQUEST_MODE, mode);
        write_register(CFG_REQUEST_PID, pid);
    endtask

    function automatic void push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) add_char(s[i]);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return 8'h30 + n;
        return (lower ? 8'h57 : 8'h37) + n;
    endfunction

    function automatic logic [7:0] random_separator();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: c = 8'h20;
            5:             c = 8'h0D;
            6:             c = 8'h3E;
            7:             c = 8'h3A;
            default: begin
                c = 8'($urandom_range(0, 255));
                while (decode_hex(c) != 5'd0) c = 8'($urandom_range(0, 255));
            end
        endcase
        return c;
    endfunction

    // digits: 2 for a byte, anything else gives a dropped token
    function automatic void add_token(input logic [7:0] b, input int digits);
        bit         lower;
        int         k;
        logic [3:0] n;
        lower = ($urandom_range(0, 1) != 0);
        if (reply_text.size() != 0 && $urandom_range(0, 99) >= 4)
            add_char(random_separator());
        for (k = 0; k < digits; k++) begin
            n = (k == digits - 1) ? b[3:0] :
                (k == digits - 2) ? b[7:4] : 4'($urandom_range(0, 15));
            add_char(hex_char(n, lower));
        end
    endfunction

    function automatic void build_random_reply();
        int         kind;
        int         n;
        int         k;
        int         r;
        logic [7:0] resp;
        logic [7:0] ch;
        resp = cfg_mode + RESPONSE_OFFSET;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            n = $urandom_range(1, 20);
            for (k = 0; k < n; k++) begin
                ch = 8'($urandom_range(0, 255));
                add_char(ch);
            end
            return;
        end
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++)
            add_token(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0 ? 3 : 2);
        add_token(resp, 2);
        if (kind < 22) add_token(cfg_pid ^ 8'($urandom_range(1, 255)), 2);
        else add_token(cfg_pid, 2);
        n = $urandom_range(0, 11);
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                ch = 8'($urandom_range(0, 255));
                add_char(ch);
            end else if (r < 10) begin
                add_token(8'($urandom_range(0, 255)),
                          $urandom_range(0, 1) ? 1 : $urandom_range(3, 5));
            end else if (r < 15) begin
                add_token($urandom_range(0, 1) ? resp : cfg_pid, 2);
            end else begin
                add_token(8'($urandom_range(0, 255)), 2);
            end
        end
        n = $urandom_range(0, 2);
        for (k = 0; k < n; k++) add_char(random_separator());
    endfunction

    task automatic test_basic_reply();
        push_text("41 0C 1a F8>");
        send_reply();
    endtask

    // dropped tokens of one and three digits, final digit joins the last token
    task automatic test_token_lengths();
        add_char(8'h00);
        push_text("41 0C 123 4");
        add_char(8'hFF);
        push_text("7e");
        send_reply();
    endtask

    // a second pair after the match is plain data
    task automatic test_repeated_pair();
        push_text("7E8 41 0C 41 0C");
        send_reply();
    endtask

    task automatic test_no_match();
        push_text("NO DATA\r");
        send_reply();
        push_text(">");
        send_reply();
    endtask

    task automatic test_mode_wrap();
        set_request(8'hFF, 8'h00);
        push_text("3F 00 5A");
        send_reply();
        set_request(8'hC0, 8'hFF);
        push_text("00 ff 80");
        send_reply();
    endtask

    task automatic test_pressure();
        int i;
        for (i = 0; i < 3; i++) begin
            wait_drain();
            build_random_reply();
            send_reply();
        end
    endtask

    task automatic test_random_replies();
        int         replies;
        logic [7:0] mode;
        logic [7:0] pid;
        replies = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (replies % 15 == 0) begin
                case ($urandom_range(0, 4))
                    0:       mode = 8'h00;
                    1:       mode = 8'hFF;
                    2:       mode = 8'hBF;
                    3:       mode = MODE_RESET;
                    default: mode = 8'($urandom_range(0, 255));
                endcase
                case ($urandom_range(0, 3))
                    0:       pid = 8'h00;
                    1:       pid = 8'hFF;
                    default: pid = 8'($urandom_range(0, 255));
                endcase
                set_request(mode, pid);
            end
            quiet_phase = (replies >= 30 && replies < 42);
            if ($urandom_range(0, 9) == 0) wait_drain();
            build_random_reply();
            send_reply();
            replies++;
        end
        quiet_phase = 1'b0;
    endtask

    initial begin
        clear_matcher();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_basic_reply();
        test_token_lengths();
        test_repeated_pair();
        test_no_match();
        test_mode_wrap();
        test_pressure();
        test_random_replies();
        wait_drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ohm_pkg.sv
hdl/ohm_token.sv
hdl/ohm_match.sv
hdl/obd_response_hex_matcher_core.sv
tb/sv/obd_response_hex_matcher_core_tb.sv
